// ===== sv/six_button_pad_select_counter_assert.svh =====
`ifndef SIX_BUTTON_PAD_SELECT_COUNTER_ASSERT_SVH
`define SIX_BUTTON_PAD_SELECT_COUNTER_ASSERT_SVH

// Condition in one cycle implies a consequence in the same cycle, outside reset
`define SBPSC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition in one cycle implies a consequence in the next cycle, outside reset
`define SBPSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset
`define SBPSC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sbpsc_pkg.sv =====
package sbpsc_pkg;

   // Operation codes carried by each request transfer
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_POLL  = 2'd3
   } op_type;

   // Button bit positions (1 = pressed)
   localparam int BTN_UP    = 0;
   localparam int BTN_DOWN  = 1;
   localparam int BTN_LEFT  = 2;
   localparam int BTN_RIGHT = 3;
   localparam int BTN_A     = 4;
   localparam int BTN_B     = 5;
   localparam int BTN_C     = 6;
   localparam int BTN_X     = 7;
   localparam int BTN_Y     = 8;
   localparam int BTN_Z     = 9;
   localparam int BTN_MODE  = 10;
   localparam int BTN_START = 11;

   // Select line position in the written byte
   localparam int SELECT_BIT = 6;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1600;
   localparam logic [2:0]  EDGE_MAX      = 3'd4;

   // Edge count values with a special meaning on the port
   localparam logic [2:0]  EDGE_TYPE_CODE = 3'd2;
   localparam logic [2:0]  EDGE_EXTENDED  = 3'd3;

   // Pad state as seen by the read multiplexer
   typedef struct packed {
      logic [2:0]  edge_count;
      logic        select_level;
      logic [11:0] buttons;
      logic [3:0]  dirs;
   } pad_state_type;

endpackage

// ===== sv/sbpsc_port_mux.sv =====
module sbpsc_port_mux
   import sbpsc_pkg::*;
(
   input  pad_state_type pad_state,
   output logic [5:0]    read_data
);

   logic [3:0] low_lines;
   logic [5:0] data_high;

   // Active-high view of the port lines, chosen by select level and edge count
   always_comb begin
      low_lines = 4'h0;
      if (!pad_state.select_level) begin
         case (pad_state.edge_count) inside
            3'd0, 3'd1, EDGE_MAX: begin
               low_lines = {2'b11, pad_state.dirs[BTN_DOWN], pad_state.dirs[BTN_UP]};
            end
            EDGE_TYPE_CODE: begin
               low_lines = 4'hF;
            end
            default: begin
               low_lines = 4'h0;
            end
         endcase
         data_high = {pad_state.buttons[BTN_START], pad_state.buttons[BTN_A], low_lines};
      end else begin
         case (pad_state.edge_count) inside
            EDGE_EXTENDED: begin
               low_lines = {pad_state.buttons[BTN_MODE], pad_state.buttons[BTN_X],
                            pad_state.buttons[BTN_Y], pad_state.buttons[BTN_Z]};
            end
            [3'd0:EDGE_MAX]: begin
               low_lines = pad_state.dirs;
            end
            default: begin
               low_lines = 4'h0;
            end
         endcase
         data_high = {pad_state.buttons[BTN_C], pad_state.buttons[BTN_B], low_lines};
      end
   end

   // Lines are active low
   assign read_data = ~data_high;

endmodule

// ===== sv/six_button_pad_select_counter.sv =====
// Six-button pad port model. One request transfer is taken every clock unless stalled: a
// tick counts the select timeout down, a write updates the select line and its rising-edge
// count (saturating at four), a poll stores the buttons and the opposite-direction latches,
// and a read returns the six active-low port lines. A read result goes to a two-entry output
// buffer (result and skid registers), which lets requests keep flowing while a response is
// stalled, so req_stall rises only when both entries hold untaken results. Non-read requests
// produce no response. The user must write the timeout reload through the csr port only
// while no request is in flight; the block itself does not enforce it.
module six_button_pad_select_counter
   import sbpsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_write_byte,
   input  logic [11:0] req_buttons,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_read_data
);

   logic [15:0] timeout_reload_ff, timeout_reload_in;
   logic [2:0]  edge_count_ff, edge_count_in;
   logic [15:0] timeout_left_ff, timeout_left_in;
   logic        select_level_ff, select_level_in;
   logic [11:0] buttons_ff, buttons_in;
   logic [3:0]  dirs_ff, dirs_in;
   logic [1:0]  hold_ff, hold_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_data_ff, rsp_data_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [5:0]  skid_data_ff, skid_data_in;

   logic          req_transfer;
   logic          read_transfer;
   logic          rsp_transfer;
   logic [15:0]   timeout_dec;
   logic          new_select;
   pad_state_type pad_state;
   logic [5:0]    port_data;

   assign req_transfer  = req_valid && !req_stall;
   assign read_transfer = req_transfer && (req_operation == OP_READ);
   assign rsp_transfer  = rsp_valid_ff && !rsp_stall;
   assign timeout_dec   = timeout_left_ff - 16'd1;
   assign new_select    = req_write_byte[SELECT_BIT];

   // Configuration register
   always_comb begin
      timeout_reload_in = csr_write_enable ? csr_write_data : timeout_reload_ff;
   end

   // Pad state update for the accepted request
   always_comb begin
      edge_count_in   = edge_count_ff;
      timeout_left_in = timeout_left_ff;
      select_level_in = select_level_ff;
      buttons_in      = buttons_ff;
      dirs_in         = dirs_ff;
      hold_in         = hold_ff;
      if (req_transfer) begin
         case (op_type'(req_operation))
            OP_TICK: begin
               if (timeout_left_ff != 16'd0) begin
                  timeout_left_in = timeout_dec;
                  if (timeout_dec == 16'd0) begin
                     edge_count_in = 3'd0;
                  end
               end
            end
            OP_WRITE: begin
               // rising edge of select bumps the count and restarts the timeout
               if (!select_level_ff && new_select) begin
                  if (edge_count_ff < EDGE_MAX) begin
                     edge_count_in = edge_count_ff + 3'd1;
                  end
                  timeout_left_in = timeout_reload_ff;
               end
               select_level_in = new_select;
            end
            OP_POLL: begin
               buttons_in = req_buttons;
               // each direction pair: follow the buttons, or swap once while both held
               for (int p = 0; p < 2; p++) begin
                  if (!(req_buttons[2*p] && req_buttons[2*p+1])) begin
                     hold_in[p]       = 1'b0;
                     dirs_in[2*p]     = req_buttons[2*p];
                     dirs_in[2*p+1]   = req_buttons[2*p+1];
                  end else if (!hold_ff[p]) begin
                     hold_in[p]       = 1'b1;
                     dirs_in[2*p]     = dirs_ff[2*p+1];
                     dirs_in[2*p+1]   = dirs_ff[2*p];
                  end
               end
            end
            default: begin
               // reads leave the state alone
            end
         endcase
      end
   end

   // Port line selection
   assign pad_state = '{
      edge_count:   edge_count_ff,
      select_level: select_level_ff,
      buttons:      buttons_ff,
      dirs:         dirs_ff
   };

   sbpsc_port_mux u_port_mux (
      .pad_state (pad_state),
      .read_data (port_data)
   );

   // Output buffer: result register with a skid register behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_transfer) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (read_transfer) begin
         if (!rsp_valid_ff || rsp_transfer) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = port_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = port_data;
         end
      end else if (rsp_transfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_reload_ff <= TIMEOUT_RESET;
         edge_count_ff     <= 3'd0;
         timeout_left_ff   <= 16'd0;
         select_level_ff   <= 1'b0;
         buttons_ff        <= 12'd0;
         dirs_ff           <= 4'd0;
         hold_ff           <= 2'd0;
         rsp_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         timeout_reload_ff <= timeout_reload_in;
         edge_count_ff     <= edge_count_in;
         timeout_left_ff   <= timeout_left_in;
         select_level_ff   <= select_level_in;
         buttons_ff        <= buttons_in;
         dirs_ff           <= dirs_in;
         hold_ff           <= hold_in;
         rsp_valid_ff      <= rsp_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   // Response payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall     = skid_valid_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

// ===== sv/sbpsc_checker.sv =====
`include "six_button_pad_select_counter_assert.svh"

module sbpsc_checker
   import sbpsc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [5:0]  rsp_read_data
);

   logic req_transfer;

   assign req_transfer = req_valid && !req_stall;

   // No response may be pending straight after reset
   `SBPSC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "response valid after reset")

   // A stalled response stays and holds its data
   `SBPSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_read_data), "stalled response changed")

   // Requests are only held off while a response is waiting
   `SBPSC_ASSERT_SAME(a_stall_needs_rsp, clock, reset, req_stall, rsp_valid, "request stalled with empty output")

   // A read taken into an empty output shows up in the next cycle
   `SBPSC_ASSERT_NEXT(a_read_to_rsp, clock, reset, req_transfer && (req_operation == OP_READ) && !rsp_valid, rsp_valid, "read produced no response")

   // Non-read requests into an empty output produce nothing
   `SBPSC_ASSERT_NEXT(a_no_spurious, clock, reset, req_transfer && (req_operation != OP_READ) && !rsp_valid, !rsp_valid, "response without a read")

endmodule

bind six_button_pad_select_counter sbpsc_checker u_sbpsc_checker (.*);

// ===== dv/tb_six_button_pad_select_counter.sv =====
`timescale 1ns / 1ps

module tb_six_button_pad_select_counter;
   import sbpsc_pkg::*;

   // One request transfer as queued for the driver
   typedef struct {
      op_type      op;
      logic [7:0]  wb;
      logic [11:0] bt;
   } pad_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = OP_TICK;
   logic [7:0]  req_write_byte = '0;
   logic [11:0] req_buttons = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_read_data;

   six_button_pad_select_counter dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_write_byte   (req_write_byte),
      .req_buttons      (req_buttons),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data)
   );

   always #2 clock = ~clock;

   // Stimulus and expectation stores
   pad_cmd_type pad_cmds_pending[$];
   logic [5:0]  port_lines_due[$];
   pad_cmd_type drive_cmd;
   int          cmds_queued = 0;
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          long_hold_requests = 0;
   int          long_hold_served = 0;
   int          hold_left = 0;
   logic        req_moved = 1'b0;

   // Pad state as the predictor sees it
   logic [15:0] sel_reload;
   logic [15:0] sel_timeout_left;
   logic [2:0]  pad_edges;
   logic        sel_level;
   logic [11:0] pad_buttons;
   logic [3:0]  dir_latches;
   logic [1:0]  pair_hold;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // Port lines for the current select level and edge count, active low
   function automatic logic [5:0] port_lines();
      logic [5:0] d;
      d = '0;
      if (!sel_level) begin
         if (pad_edges == 3'd0 || pad_edges == 3'd1 || pad_edges == EDGE_MAX)
            d[3:0] = {2'b11, dir_latches[1:0]};
         else if (pad_edges == EDGE_TYPE_CODE)
            d[3:0] = 4'hF;
         d[4] = pad_buttons[BTN_A];
         d[5] = pad_buttons[BTN_START];
      end else begin
         if (pad_edges == EDGE_EXTENDED)
            d[3:0] = {pad_buttons[BTN_MODE], pad_buttons[BTN_X],
                      pad_buttons[BTN_Y], pad_buttons[BTN_Z]};
         else if (pad_edges <= EDGE_MAX)
            d[3:0] = dir_latches;
         d[4] = pad_buttons[BTN_B];
         d[5] = pad_buttons[BTN_C];
      end
      return ~d;
   endfunction

   // Opposite directions: follow the buttons, or swap once while both are held
   task automatic latch_pair(input int lo, input int h);
      logic a, b, la, lb;
      a  = pad_buttons[lo];
      b  = pad_buttons[lo + 1];
      la = dir_latches[lo];
      lb = dir_latches[lo + 1];
      if (!(a && b)) begin
         pair_hold[h]       = 1'b0;
         dir_latches[lo]     = a;
         dir_latches[lo + 1] = b;
      end else if (!pair_hold[h]) begin
         pair_hold[h]       = 1'b1;
         dir_latches[lo]     = lb;
         dir_latches[lo + 1] = la;
      end
   endtask

   task automatic pad_port_step(input op_type op, input logic [7:0] wb, input logic [11:0] bt);
      case (op)
         OP_TICK: begin
            if (sel_timeout_left != 16'd0) begin
               sel_timeout_left = sel_timeout_left - 16'd1;
               if (sel_timeout_left == 16'd0)
                  pad_edges = 3'd0;
            end
         end
         OP_WRITE: begin
            if (!sel_level && wb[SELECT_BIT]) begin
               if (pad_edges < EDGE_MAX)
                  pad_edges = pad_edges + 3'd1;
               sel_timeout_left = sel_reload;
            end
            sel_level = wb[SELECT_BIT];
         end
         OP_READ:
            port_lines_due.push_back(port_lines());
         default: begin
            pad_buttons = bt;
            latch_pair(BTN_UP, 0);
            latch_pair(BTN_LEFT, 1);
         end
      endcase
   endtask

   // Monitor: predict on request transfers, check response transfers
   always @(posedge clock) begin
      req_moved <= req_valid && !req_stall && !reset;
      if (reset) begin
         sel_reload       = TIMEOUT_RESET;
         sel_timeout_left = '0;
         pad_edges        = '0;
         sel_level        = 1'b0;
         pad_buttons      = '0;
         dir_latches      = '0;
         pair_hold        = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (port_lines_due.size() == 0)
               report_mismatch($sformatf("unexpected read_data %h", rsp_read_data));
            else if (rsp_read_data !== port_lines_due[0])
               report_mismatch($sformatf("read_data %h, expected %h",
                                         rsp_read_data, port_lines_due[0]));
            if (port_lines_due.size() != 0)
               void'(port_lines_due.pop_front());
         end
         if (csr_write_enable)
            sel_reload = csr_write_data;
         if (req_valid && !req_stall)
            pad_port_step(op_type'(req_operation), req_write_byte, req_buttons);
      end
   end

   // Driver: next item goes out once the previous one has transferred
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_moved) begin
         if (pad_cmds_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_cmd = pad_cmds_pending.pop_front();
            req_valid      <= 1'b1;
            req_operation  <= drive_cmd.op;
            req_write_byte <= drive_cmd.wb;
            req_buttons    <= drive_cmd.bt;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall, with an occasional long hold-off on request
   always @(negedge clock) begin
      if (long_hold_served != long_hold_requests) begin
         long_hold_served++;
         hold_left = 120;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic queue_cmd(input op_type op, input logic [7:0] wb, input logic [11:0] bt);
      pad_cmd_type c;
      c.op = op;
      c.wb = wb;
      c.bt = bt;
      pad_cmds_pending.push_back(c);
      cmds_queued++;
   endtask

   // Buttons for a poll, often with an opposite pair held together
   function automatic logic [11:0] poll_pattern();
      logic [11:0] b;
      b = 12'($urandom_range(0, 4095));
      case ($urandom_range(0, 4))
         0: b[BTN_DOWN:BTN_UP] = 2'b11;
         1: b[BTN_RIGHT:BTN_LEFT] = 2'b11;
         2: b[BTN_RIGHT:BTN_UP] = 4'hF;
         default: ;
      endcase
      return b;
   endfunction

   // Mostly host read cycles, with polls, tick runs and odd items mixed in
   task automatic queue_pad_traffic(input int n);
      int target;
      int pick;
      target = cmds_queued + n;
      while (cmds_queued < target) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            repeat ($urandom_range(1, 4)) begin
               queue_cmd(OP_WRITE, 8'($urandom) | 8'h40, 12'($urandom));
               queue_cmd(OP_READ, 8'($urandom), 12'($urandom));
               queue_cmd(OP_WRITE, 8'($urandom) & 8'hBF, 12'($urandom));
               queue_cmd(OP_READ, 8'($urandom), 12'($urandom));
            end
         end else if (pick < 75) begin
            queue_cmd(OP_POLL, 8'($urandom), poll_pattern());
            if ($urandom_range(1))
               queue_cmd(OP_READ, 8'($urandom), 12'($urandom));
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 6))
               queue_cmd(OP_TICK, 8'($urandom), 12'($urandom));
            queue_cmd(OP_READ, 8'($urandom), 12'($urandom));
         end else begin
            queue_cmd(op_type'($urandom_range(0, 3)), 8'($urandom), 12'($urandom));
         end
      end
   endtask

   // Everything sent and answered, then the block is left to settle
   task automatic wait_drained();
      while (pad_cmds_pending.size() != 0 || req_valid || port_lines_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reload(input logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Run limit
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: latches, edge counts zero to four across both select levels, saturation, expiry
      write_reload(16'd2);
      set_idling(0, 0);
      queue_cmd(OP_READ, 8'h00, 12'h000);
      queue_cmd(OP_POLL, 8'h00, 12'hFFF);
      queue_cmd(OP_READ, 8'h00, 12'h000);
      queue_cmd(OP_POLL, 8'h00, 12'h001);
      queue_cmd(OP_POLL, 8'h00, 12'h003);
      queue_cmd(OP_POLL, 8'h00, 12'h00B);
      queue_cmd(OP_POLL, 8'h00, 12'hF8F);
      queue_cmd(OP_WRITE, 8'hBF, 12'h000);
      queue_cmd(OP_READ, 8'h00, 12'h000);
      queue_cmd(OP_WRITE, 8'h40, 12'h000);
      queue_cmd(OP_READ, 8'h00, 12'h000);
      queue_cmd(OP_WRITE, 8'h00, 12'h000);
      queue_cmd(OP_WRITE, 8'hFF, 12'h000);
      queue_cmd(OP_READ, 8'h00, 12'h000);
      queue_cmd(OP_WRITE, 8'h3F, 12'h000);
      queue_cmd(OP_READ, 8'h00, 12'h000);
      queue_cmd(OP_WRITE, 8'h40, 12'h000);
      queue_cmd(OP_READ, 8'h00, 12'h000);
      queue_cmd(OP_WRITE, 8'h00, 12'h000);
      queue_cmd(OP_READ, 8'h00, 12'h000);
      queue_cmd(OP_WRITE, 8'h40, 12'h000);
      queue_cmd(OP_WRITE, 8'h00, 12'h000);
      queue_cmd(OP_WRITE, 8'h40, 12'h000);
      queue_cmd(OP_READ, 8'h00, 12'h000);
      queue_cmd(OP_TICK, 8'h00, 12'h000);
      queue_cmd(OP_TICK, 8'h00, 12'h000);
      queue_cmd(OP_READ, 8'hFF, 12'hFFF);
      wait_drained();

      // Random phases over several reload settings and idling patterns
      write_reload(16'd1);
      set_idling(25, 83);
      queue_pad_traffic(220);
      wait_drained();

      write_reload(16'd5);
      set_idling(83, 25);
      queue_pad_traffic(220);
      wait_drained();

      // Zero reload: a rising edge of select clears the timeout, so no expiry follows it
      write_reload(16'd0);
      set_idling(0, 0);
      queue_pad_traffic(100);
      wait_drained();

      write_reload(16'hFFFF);
      queue_pad_traffic(80);
      wait_drained();

      // Back pressure: long receiver hold while reads keep coming
      write_reload(TIMEOUT_RESET);
      queue_pad_traffic(20);
      @(posedge clock);
      long_hold_requests++;
      repeat (60)
         queue_cmd(OP_READ, 8'($urandom), 12'($urandom));
      wait_drained();
      queue_pad_traffic(60);
      wait_drained();

      repeat (10) @(posedge clock);
      if (port_lines_due.size() != 0)
         report_mismatch($sformatf("%0d reads never answered", port_lines_due.size()));
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== six_button_pad_select_counter.f =====
+incdir+sv
sv/sbpsc_pkg.sv
sv/sbpsc_port_mux.sv
sv/six_button_pad_select_counter.sv
sv/sbpsc_checker.sv
dv/tb_six_button_pad_select_counter.sv
